FILE: rtl/assert_macros.svh
// Assertion helpers shared by the ring buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define OSR_ASSERT_NOW(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define OSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define OSR_ASSERT_NOW(label, clk, rst, expr)

`define OSR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/osr_pkg.sv
package osr_pkg;

   localparam int DEPTH   = 4096;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = 13;
   localparam int DATA_W  = 8;
   localparam int TOTAL_W = 48;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TRUNC = 2'd2;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [DATA_W-1:0] data_byte;
      logic [CNT_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic               read_valid;
      logic [CNT_W-1:0]   fill_length;
      logic [TOTAL_W-1:0] bytes_total;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

endpackage

FILE: rtl/osr_ctrl.sv
`include "assert_macros.svh"

module osr_ctrl
   import osr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_strobe,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign accept     = start && !busy;

   assign cmd.load    = accept;
   assign cmd.execute = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `OSR_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `OSR_ASSERT_NEXT(a_exec_done, clock, reset, cmd.execute, rsp_strobe)
   `OSR_ASSERT_NOW(a_strobe_free, clock, reset, !(rsp_strobe && busy))

endmodule

FILE: rtl/osr_dpath.sv
`include "assert_macros.svh"

module osr_dpath
   import osr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req,
   input  logic             csr_write_en,
   input  logic [CNT_W-1:0] csr_write_data,
   output rsp_type          rsp
);

   logic [DATA_W-1:0]  mem [DEPTH];

   req_type            req_ff;
   logic [CNT_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   cap_in;
   logic [ADDR_W-1:0]  head_ff;
   logic [ADDR_W-1:0]  head_in;
   logic [CNT_W-1:0]   held_ff;
   logic [CNT_W-1:0]   held_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [DATA_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;

   logic [CNT_W:0]     head_ext;
   logic [CNT_W:0]     cap_ext;
   logic [CNT_W:0]     head_inc;
   logic [CNT_W:0]     rd_sum;
   logic [CNT_W:0]     rd_wrap;
   logic [CNT_W-1:0]   discard;
   logic [CNT_W:0]     tr_sum;
   logic [CNT_W:0]     tr_wrap;
   logic               in_range;
   logic               do_write;
   logic               do_read;

   assign head_ext = (CNT_W + 1)'(head_ff);
   assign cap_ext  = {1'b0, cap_ff};
   assign head_inc = head_ext + 1'b1;
   assign in_range = (req_ff.position < held_ff);
   assign do_write = cmd.execute && (req_ff.opcode == OP_WRITE);
   assign do_read  = cmd.execute && (req_ff.opcode == OP_READ) && in_range;

   assign rd_sum  = head_ext + cap_ext - {1'b0, held_ff} + {1'b0, req_ff.position};
   assign rd_wrap = (rd_sum >= cap_ext) ? rd_sum - cap_ext : rd_sum;

   assign discard = held_ff - req_ff.position;
   assign tr_sum  = head_ext + cap_ext - {1'b0, discard};
   assign tr_wrap = (tr_sum >= cap_ext) ? tr_sum - cap_ext : tr_sum;

   always_comb begin
      if (csr_write_data == '0) begin
         cap_in = CNT_W'(1);
      end else if (csr_write_data > CNT_W'(DEPTH)) begin
         cap_in = CNT_W'(DEPTH);
      end else begin
         cap_in = csr_write_data;
      end
   end

   always_comb begin
      head_in  = head_ff;
      held_in  = held_ff;
      total_in = total_ff;
      if (csr_write_en) begin
         head_in = '0;
         held_in = '0;
      end else if (cmd.execute) begin
         case (req_ff.opcode)
            OP_WRITE: begin
               head_in  = (head_inc >= cap_ext) ? '0 : head_inc[ADDR_W-1:0];
               held_in  = (held_ff < cap_ff) ? held_ff + 1'b1 : held_ff;
               total_in = total_ff + 1'b1;
            end
            OP_TRUNC: begin
               if (in_range) begin
                  head_in  = tr_wrap[ADDR_W-1:0];
                  held_in  = req_ff.position;
                  total_in = total_ff - TOTAL_W'(discard);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CNT_W'(DEPTH);
         head_ff     <= '0;
         held_ff     <= '0;
         total_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) cap_ff <= cap_in;
         head_ff  <= head_in;
         held_ff  <= held_in;
         total_ff <= total_in;
         if (cmd.execute) rd_valid_ff <= do_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
   end

   always_ff @(posedge clock) begin
      if (do_write) mem[head_ff] <= req_ff.data_byte;
      if (cmd.execute) rd_data_ff <= mem[rd_wrap[ADDR_W-1:0]];
   end

   assign rsp.read_data   = rd_valid_ff ? rd_data_ff : '0;
   assign rsp.read_valid  = rd_valid_ff;
   assign rsp.fill_length = held_ff;
   assign rsp.bytes_total = total_ff;

   `OSR_ASSERT_NOW(a_held_le_cap, clock, reset, held_ff <= cap_ff)
   `OSR_ASSERT_NOW(a_head_lt_cap, clock, reset, head_ext < cap_ext)
   `OSR_ASSERT_NEXT(a_cfg_empties, clock, reset, csr_write_en,
                    (held_ff == '0) && (head_ff == '0))

endmodule

FILE: rtl/overwriting_scrollback_ring.sv
// Channel   Handshake            Payload
// request   start / busy         req  (opcode, data_byte, position)
// response  rsp_strobe           rsp  (read_data, read_valid, fill_length, bytes_total)
// config    csr_write_en         csr_write_data (capacity)
//
// Each beat is executed in the EXEC state against the head, fill and total
// registers and the byte memory, and its response is presented in the DONE state.
// A new beat is taken in the cycle its predecessor's response is shown.
// Reset is synchronous and empties the ring; the byte memory is not cleared.
// The response lasts exactly one cycle and cannot be stalled.
module overwriting_scrollback_ring
   import osr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req,
   output logic             rsp_strobe,
   output rsp_type          rsp,
   input  logic             csr_write_en,
   input  logic [CNT_W-1:0] csr_write_data
);

   cmd_type cmd;

   osr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   osr_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req            (req),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp            (rsp)
   );

endmodule

FILE: dv/scrollback_ring_checker.sv
module scrollback_ring_checker
   import osr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req,
   input  logic             rsp_strobe,
   input  rsp_type          rsp,
   input  logic             csr_write_en,
   input  logic [CNT_W-1:0] csr_write_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_W-1:0]  ring_bytes [DEPTH];
   int                 head;
   int                 held;
   logic [TOTAL_W-1:0] total;
   logic [CNT_W-1:0]   capacity;
   rsp_type            awaited_rsp [$];
   int                 errors = 0;

   function automatic int active_capacity();
      if (capacity == '0) return 1;
      if (capacity > DEPTH) return DEPTH;
      return int'(capacity);
   endfunction

   function automatic rsp_type apply_beat(req_type beat);
      rsp_type result;
      int      cap;
      int      slot;
      int      dropped;
      cap = active_capacity();
      result = '0;
      case (beat.opcode)
         OP_WRITE: begin
            ring_bytes[head] = beat.data_byte;
            head = (head + 1) % cap;
            if (held < cap) held++;
            total = total + 1'b1;
         end
         OP_READ: begin
            if (beat.position < held) begin
               slot = (head + cap - held + int'(beat.position)) % cap;
               result.read_data = ring_bytes[slot];
               result.read_valid = 1'b1;
            end
         end
         OP_TRUNC: begin
            if (beat.position < held) begin
               dropped = held - int'(beat.position);
               head = (head + cap - dropped) % cap;
               held = int'(beat.position);
               total = total - TOTAL_W'(dropped);
            end
         end
         default: ;
      endcase
      result.fill_length = CNT_W'(held);
      result.bytes_total = total;
      return result;
   endfunction

   task automatic check_field(string field, logic [TOTAL_W-1:0] want,
                              logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head = 0;
         held = 0;
         total = '0;
         capacity = CNT_W'(DEPTH);
         awaited_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               $error("response beat with nothing outstanding: %p", rsp);
               errors++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("read_data", TOTAL_W'(want.read_data),
                           TOTAL_W'(rsp.read_data));
               check_field("read_valid", TOTAL_W'(want.read_valid),
                           TOTAL_W'(rsp.read_valid));
               check_field("fill_length", TOTAL_W'(want.fill_length),
                           TOTAL_W'(rsp.fill_length));
               check_field("bytes_total", want.bytes_total, rsp.bytes_total);
            end
         end
         if (csr_write_en) begin
            capacity = csr_write_data;
            head = 0;
            held = 0;
         end
         if (start && !busy) awaited_rsp.push_back(apply_beat(req));
      end
      fail_count <= errors;
      pending <= awaited_rsp.size();
   end

endmodule

FILE: dv/tb_overwriting_scrollback_ring.sv
module tb_overwriting_scrollback_ring;
   timeunit 1ns;
   timeprecision 1ps;

   import osr_pkg::*;

   localparam logic [1:0] OP_IDLE = 2'd3;
   localparam int CSR_MAX = (1 << CNT_W) - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req = '0;
   logic             rsp_strobe;
   rsp_type          rsp;
   logic             csr_write_en = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;
   int               fail_count;
   int               pending;

   int idle_pct = 34;
   int eff_cap = DEPTH;
   int fill_est = 0;

   overwriting_scrollback_ring DUT (
      .clock,
      .reset,
      .start,
      .busy,
      .req,
      .rsp_strobe,
      .rsp,
      .csr_write_en,
      .csr_write_data
   );

   scrollback_ring_checker u_checker (
      .clock,
      .reset,
      .start,
      .busy,
      .req,
      .rsp_strobe,
      .rsp,
      .csr_write_en,
      .csr_write_data,
      .fail_count,
      .pending
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CNT_W-1:0] pick_position();
      if ($urandom_range(9) < 8) return CNT_W'($urandom_range(fill_est + 1));
      return CNT_W'($urandom_range(CSR_MAX));
   endfunction

   task automatic send_beat(input logic [1:0] op, input logic [DATA_W-1:0] data,
                            input logic [CNT_W-1:0] pos);
      req_type beat;
      beat.opcode = op;
      beat.data_byte = data;
      beat.position = pos;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req <= req_type'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req <= beat;
      do @(posedge clock); while (busy);
      if (op == OP_WRITE && fill_est < eff_cap) fill_est++;
      if (op == OP_TRUNC && int'(pos) < fill_est) fill_est = int'(pos);
   endtask

   task automatic wait_drained();
      int guard;
      start <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (pending != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic set_capacity(input int value);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_write_data <= CNT_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      eff_cap = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : value);
      fill_est = 0;
   endtask

   initial begin
      int phase_caps [10] = '{1, 0, 2, 3, CSR_MAX, 7, DEPTH + 1, 16, 5, 31};
      int cap;
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(OP_READ, 8'h00, 13'd0);
      send_beat(OP_TRUNC, 8'h00, 13'd0);
      send_beat(OP_IDLE, 8'hFF, CNT_W'(CSR_MAX));
      send_beat(OP_WRITE, 8'h00, 13'd0);
      send_beat(OP_WRITE, 8'hFF, CNT_W'(CSR_MAX));
      send_beat(OP_WRITE, 8'h5A, 13'd0);
      send_beat(OP_READ, 8'h00, 13'd0);
      send_beat(OP_READ, 8'hFF, 13'd2);
      send_beat(OP_READ, 8'h00, 13'd3);
      send_beat(OP_READ, 8'h00, CNT_W'(CSR_MAX));
      send_beat(OP_TRUNC, 8'h00, CNT_W'(CSR_MAX));
      send_beat(OP_TRUNC, 8'h00, 13'd3);
      send_beat(OP_TRUNC, 8'h00, 13'd2);
      send_beat(OP_READ, 8'h00, 13'd2);
      send_beat(OP_WRITE, 8'hA5, CNT_W'(CSR_MAX));
      send_beat(OP_READ, 8'h00, 13'd2);
      send_beat(OP_TRUNC, 8'hFF, 13'd0);
      send_beat(OP_READ, 8'h00, 13'd0);
      send_beat(OP_WRITE, 8'h3C, 13'd0);
      send_beat(OP_READ, 8'h00, 13'd0);

      for (int phase = 0; phase < 13; phase++) begin
         if (phase < 10) cap = phase_caps[phase];
         else if (phase == 12) cap = $urandom_range(CSR_MAX);
         else cap = $urandom_range(48, 4);
         set_capacity(cap);
         idle_pct = (phase == 5) ? 0 : 34;
         for (int n = 0; n < 90; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               send_beat(OP_WRITE, DATA_W'($urandom), CNT_W'($urandom));
            end else if (pick < 78) begin
               send_beat(OP_READ, DATA_W'($urandom), pick_position());
            end else if (pick < 92) begin
               send_beat(OP_TRUNC, DATA_W'($urandom), pick_position());
            end else begin
               send_beat(OP_IDLE, DATA_W'($urandom), CNT_W'($urandom));
            end
         end
      end

      // Stream writes at full capacity with no idle cycles in between, with a read before every 32nd write.
      set_capacity(DEPTH);
      idle_pct = 0;
      for (int n = 0; n < 64; n++) begin
         if (n % 32 == 31) send_beat(OP_READ, DATA_W'($urandom), pick_position());
         send_beat(OP_WRITE, DATA_W'($urandom), CNT_W'($urandom));
      end
      idle_pct = 34;
      send_beat(OP_READ, 8'h00, 13'd0);
      send_beat(OP_READ, 8'h00, CNT_W'(DEPTH - 1));
      send_beat(OP_READ, 8'h00, CNT_W'(DEPTH));
      send_beat(OP_TRUNC, 8'h00, CNT_W'(DEPTH));
      send_beat(OP_TRUNC, 8'h00, CNT_W'(DEPTH - 1));
      send_beat(OP_READ, 8'h00, CNT_W'(DEPTH - 2));
      send_beat(OP_READ, 8'h00, CNT_W'(DEPTH - 1));
      set_capacity(0);
      send_beat(OP_WRITE, DATA_W'($urandom), CNT_W'($urandom));
      send_beat(OP_READ, 8'h00, 13'd0);

      wait_drained();
      if (fail_count == 0 && pending == 0) begin
         $display("overwriting_scrollback_ring: match");
      end else begin
         $display("overwriting_scrollback_ring: mismatch");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("overwriting_scrollback_ring: mismatch");
      $finish;
   end

endmodule
